// ----- rtl/core/rma_pkg.sv -----
// Shared types, codes and constants of the rational mixed-number ALU.
package rma_pkg;

  localparam int VALUE_WIDTH_DEF = 64;
  localparam int PORT_WIDTH      = 64;

  localparam logic [2:0] REQ_NORM = 3'd0;
  localparam logic [2:0] REQ_ADD  = 3'd1;
  localparam logic [2:0] REQ_SUB  = 3'd2;
  localparam logic [2:0] REQ_MUL  = 3'd3;
  localparam logic [2:0] REQ_DIV  = 3'd4;
  localparam logic [2:0] REQ_CMP  = 3'd5;

  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_ZERO_DEN = 2'd1;
  localparam logic [1:0] ERR_NEGATIVE = 2'd2;
  localparam logic [1:0] ERR_DIV_ZERO = 2'd3;

  typedef enum logic [5:0] {
    OP_NOP, OP_LOAD, OP_NA_SET, OP_STRIP, OP_GCD_LOAD, OP_GSWAP, OP_GDONE, OP_GSTEP,
    OP_N_Q, OP_D_Q, OP_NFIN, OP_A_STORE_BSET, OP_B_STORE, OP_B_STORE_LCM, OP_L_SET,
    OP_N1_SET, OP_N2_SET, OP_ADD_SET, OP_SUB_SET, OP_N1_MD, OP_N2_MD,
    OP_MD3_MUL, OP_MD3_DIV, OP_MD4_MUL, OP_MD4_DIV, OP_MD5_MUL, OP_MD5_DIV,
    OP_MD7, OP_MD8, OP_OUT_VAL, OP_OUT_ERR, OP_OUT_CMP, OP_OUT_ZERO
  } dp_op_t;

  typedef enum logic [3:0] {
    SRC_X, SRC_Y, SRC_N, SRC_D, SRC_G, SRC_Q, SRC_R, SRC_AD,
    SRC_BD, SRC_AN, SRC_BN, SRC_AW, SRC_BW, SRC_L, SRC_N1, SRC_N2
  } src_t;

  typedef struct packed {
    dp_op_t     op;
    logic       ustart;
    logic       umul;
    src_t       ua;
    src_t       ub;
    logic [1:0] err;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       d_zero;
    logic       n_zero;
    logic       both_even;
    logic       y_zero;
    logic       ubusy;
    logic       sub_neg;
  } dp_stat_t;

endpackage

// ----- rtl/core/rma_unit.sv -----
// Shared iterative unit: shift-add multiply and restoring divide, one bit a cycle.
module rma_unit #(
  parameter int W = rma_pkg::VALUE_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic         mul,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         busy,
  output logic [W-1:0] q,
  output logic [W-1:0] r
);

  localparam int CW = $clog2(W + 1);

  logic [CW-1:0] cnt;
  logic          mode;
  logic [W-1:0]  m;
  logic [W-1:0]  qr;
  logic [W-1:0]  rem;
  logic [W:0]    rs;
  logic          ge;

  assign rs = {rem, qr[W-1]};
  assign ge = rs >= {1'b0, m};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mode <= mul;
      rem  <= '0;
      if (mul) begin
        m  <= a;
        qr <= b;
      end else begin
        m  <= b;
        qr <= a;
      end
    end else if (busy) begin
      if (mode) begin
        if (qr[0]) begin
          rem <= rem + m;
        end
        m  <= m << 1;
        qr <= qr >> 1;
      end else if (ge) begin
        rem <= W'(rs - {1'b0, m});
        qr  <= {qr[W-2:0], 1'b1};
      end else begin
        rem <= rs[W-1:0];
        qr  <= {qr[W-2:0], 1'b0};
      end
    end
  end

  assign q = qr;
  assign r = rem;

endmodule

// ----- rtl/core/rma_dp.sv -----
// Datapath: operand and working registers, result registers, shared arithmetic unit.
module rma_dp #(
  parameter int W = rma_pkg::VALUE_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  rma_pkg::dp_cmd_t            cmd,
  output rma_pkg::dp_stat_t           st,
  input  logic [2:0]                  req_type,
  input  logic [rma_pkg::PORT_WIDTH-1:0] a_integer,
  input  logic [rma_pkg::PORT_WIDTH-1:0] a_numerator,
  input  logic [rma_pkg::PORT_WIDTH-1:0] a_denominator,
  input  logic [rma_pkg::PORT_WIDTH-1:0] b_integer,
  input  logic [rma_pkg::PORT_WIDTH-1:0] b_numerator,
  input  logic [rma_pkg::PORT_WIDTH-1:0] b_denominator,
  output logic                        done,
  output logic [rma_pkg::PORT_WIDTH-1:0] r_integer,
  output logic [rma_pkg::PORT_WIDTH-1:0] r_numerator,
  output logic [rma_pkg::PORT_WIDTH-1:0] r_denominator,
  output logic                        is_less,
  output logic                        is_equal,
  output logic [1:0]                  error_code
);

  localparam int PW = rma_pkg::PORT_WIDTH;

  logic [2:0]   op;
  logic [W-1:0] aw, an, ad, bw, bn, bd;
  logic [W-1:0] wr, nr, dr, xr, yr, gr, lr, n1, n2;
  logic [W-1:0] ua, ub, uq, ur;
  logic         borrow;
  logic         lt, eq;

  rma_unit #(.W(W)) u_unit (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.ustart),
    .mul   (cmd.umul),
    .a     (ua),
    .b     (ub),
    .busy  (st.ubusy),
    .q     (uq),
    .r     (ur)
  );

  always_comb begin
    case (cmd.ua)
      rma_pkg::SRC_X:  ua = xr;
      rma_pkg::SRC_Y:  ua = yr;
      rma_pkg::SRC_N:  ua = nr;
      rma_pkg::SRC_D:  ua = dr;
      rma_pkg::SRC_G:  ua = gr;
      rma_pkg::SRC_Q:  ua = uq;
      rma_pkg::SRC_R:  ua = ur;
      rma_pkg::SRC_AD: ua = ad;
      rma_pkg::SRC_BD: ua = bd;
      rma_pkg::SRC_AN: ua = an;
      rma_pkg::SRC_BN: ua = bn;
      rma_pkg::SRC_AW: ua = aw;
      rma_pkg::SRC_BW: ua = bw;
      rma_pkg::SRC_L:  ua = lr;
      rma_pkg::SRC_N1: ua = n1;
      rma_pkg::SRC_N2: ua = n2;
      default:         ua = xr;
    endcase
  end

  always_comb begin
    case (cmd.ub)
      rma_pkg::SRC_X:  ub = xr;
      rma_pkg::SRC_Y:  ub = yr;
      rma_pkg::SRC_N:  ub = nr;
      rma_pkg::SRC_D:  ub = dr;
      rma_pkg::SRC_G:  ub = gr;
      rma_pkg::SRC_Q:  ub = uq;
      rma_pkg::SRC_R:  ub = ur;
      rma_pkg::SRC_AD: ub = ad;
      rma_pkg::SRC_BD: ub = bd;
      rma_pkg::SRC_AN: ub = an;
      rma_pkg::SRC_BN: ub = bn;
      rma_pkg::SRC_AW: ub = aw;
      rma_pkg::SRC_BW: ub = bw;
      rma_pkg::SRC_L:  ub = lr;
      rma_pkg::SRC_N1: ub = n1;
      rma_pkg::SRC_N2: ub = n2;
      default:         ub = yr;
    endcase
  end

  assign borrow = n1 < n2;
  assign lt     = (aw == bw) ? borrow : (aw < bw);
  assign eq     = (aw == bw) && (an == bn) && (ad == bd);

  assign st.op        = op;
  assign st.d_zero    = dr == '0;
  assign st.n_zero    = nr == '0;
  assign st.both_even = !(nr[0] | dr[0]);
  assign st.y_zero    = yr == '0;
  assign st.sub_neg   = (aw < bw) || ((aw == bw) && borrow);

  always_ff @(posedge clk) begin
    case (cmd.op)
      rma_pkg::OP_LOAD: begin
        op <= req_type;
        aw <= a_integer[W-1:0];
        an <= a_numerator[W-1:0];
        ad <= a_denominator[W-1:0];
        bw <= b_integer[W-1:0];
        bn <= b_numerator[W-1:0];
        bd <= b_denominator[W-1:0];
      end
      rma_pkg::OP_NA_SET: begin
        wr <= aw;
        nr <= an;
        dr <= ad;
      end
      rma_pkg::OP_STRIP: begin
        nr <= nr >> 1;
        dr <= dr >> 1;
      end
      rma_pkg::OP_GCD_LOAD: begin
        xr <= nr;
        yr <= dr;
      end
      rma_pkg::OP_GSWAP: begin
        if (xr < yr) begin
          xr <= yr;
          yr <= xr;
        end
      end
      rma_pkg::OP_GDONE: gr <= xr;
      rma_pkg::OP_GSTEP: begin
        xr <= yr;
        yr <= ur;
      end
      rma_pkg::OP_N_Q: nr <= uq;
      rma_pkg::OP_D_Q: dr <= uq;
      rma_pkg::OP_NFIN: begin
        wr <= wr + uq;
        nr <= ur;
      end
      rma_pkg::OP_A_STORE_BSET: begin
        aw <= wr;
        an <= nr;
        ad <= dr;
        wr <= bw;
        nr <= bn;
        dr <= bd;
      end
      rma_pkg::OP_B_STORE: begin
        bw <= wr;
        bn <= nr;
        bd <= dr;
      end
      rma_pkg::OP_B_STORE_LCM: begin
        bw <= wr;
        bn <= nr;
        bd <= dr;
        xr <= ad;
        yr <= dr;
      end
      rma_pkg::OP_L_SET:  lr <= ur;
      rma_pkg::OP_N1_SET: n1 <= ur;
      rma_pkg::OP_N2_SET: n2 <= ur;
      rma_pkg::OP_ADD_SET: begin
        wr <= aw + bw;
        nr <= n1 + n2;
        dr <= lr;
      end
      rma_pkg::OP_SUB_SET: begin
        if (borrow) begin
          wr <= aw - bw - 1'b1;
          nr <= n1 + lr - n2;
        end else begin
          wr <= aw - bw;
          nr <= n1 - n2;
        end
        dr <= lr;
      end
      rma_pkg::OP_N1_MD: n1 <= ur + an;
      rma_pkg::OP_N2_MD: n2 <= ur + bn;
      rma_pkg::OP_MD3_MUL: begin
        nr <= n1;
        dr <= bd;
      end
      rma_pkg::OP_MD3_DIV: begin
        nr <= n1;
        dr <= n2;
      end
      rma_pkg::OP_MD4_MUL: begin
        n1 <= nr;
        bd <= dr;
        nr <= n2;
        dr <= ad;
      end
      rma_pkg::OP_MD4_DIV: begin
        n1 <= nr;
        n2 <= dr;
        nr <= ad;
        dr <= bd;
      end
      rma_pkg::OP_MD5_MUL: begin
        n2 <= nr;
        ad <= dr;
      end
      rma_pkg::OP_MD5_DIV: begin
        ad <= nr;
        bd <= dr;
      end
      rma_pkg::OP_MD7: begin
        nr <= ur;
        wr <= '0;
      end
      rma_pkg::OP_MD8: dr <= ur;
      rma_pkg::OP_OUT_VAL: begin
        r_integer     <= PW'(wr);
        r_numerator   <= PW'(nr);
        r_denominator <= PW'(dr);
        is_less       <= 1'b0;
        is_equal      <= 1'b0;
        error_code    <= rma_pkg::ERR_OK;
      end
      rma_pkg::OP_OUT_ERR: begin
        r_integer     <= '0;
        r_numerator   <= '0;
        r_denominator <= '0;
        is_less       <= 1'b0;
        is_equal      <= 1'b0;
        error_code    <= cmd.err;
      end
      rma_pkg::OP_OUT_CMP: begin
        r_integer     <= '0;
        r_numerator   <= '0;
        r_denominator <= '0;
        is_less       <= lt;
        is_equal      <= eq;
        error_code    <= rma_pkg::ERR_OK;
      end
      rma_pkg::OP_OUT_ZERO: begin
        r_integer     <= '0;
        r_numerator   <= '0;
        r_denominator <= '0;
        is_less       <= 1'b0;
        is_equal      <= 1'b0;
        error_code    <= rma_pkg::ERR_OK;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (cmd.op == rma_pkg::OP_OUT_VAL) || (cmd.op == rma_pkg::OP_OUT_ERR) ||
              (cmd.op == rma_pkg::OP_OUT_CMP) || (cmd.op == rma_pkg::OP_OUT_ZERO);
    end
  end

endmodule

// ----- rtl/core/rma_ctrl.sv -----
// Controller: sequences normalize, GCD, LCM and multiply/divide steps over the datapath.
module rma_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  rma_pkg::dp_stat_t st,
  output rma_pkg::dp_cmd_t  cmd
);

  typedef enum logic [33:0] {
    S_IDLE     = 34'd1 << 0,
    S_DISPATCH = 34'd1 << 1,
    S_NORM     = 34'd1 << 2,
    S_SHR      = 34'd1 << 3,
    S_STRIP    = 34'd1 << 4,
    S_GCD      = 34'd1 << 5,
    S_GLOOP    = 34'd1 << 6,
    S_GSTEP    = 34'd1 << 7,
    S_WAIT     = 34'd1 << 8,
    S_SHR_G1   = 34'd1 << 9,
    S_SHR_G2   = 34'd1 << 10,
    S_SHR_G3   = 34'd1 << 11,
    S_NQ       = 34'd1 << 12,
    S_NFIN     = 34'd1 << 13,
    S_A_DONE   = 34'd1 << 14,
    S_B_DONE   = 34'd1 << 15,
    S_L1       = 34'd1 << 16,
    S_L2       = 34'd1 << 17,
    S_L3       = 34'd1 << 18,
    S_L4       = 34'd1 << 19,
    S_L5       = 34'd1 << 20,
    S_L6       = 34'd1 << 21,
    S_L7       = 34'd1 << 22,
    S_L8       = 34'd1 << 23,
    S_MD0      = 34'd1 << 24,
    S_MD1      = 34'd1 << 25,
    S_MD2      = 34'd1 << 26,
    S_MD3      = 34'd1 << 27,
    S_MD4      = 34'd1 << 28,
    S_MD5      = 34'd1 << 29,
    S_MD6      = 34'd1 << 30,
    S_MD7      = 34'd1 << 31,
    S_MD8      = 34'd1 << 32,
    S_FIN_VAL  = 34'd1 << 33
  } state_t;

  state_t state, state_next;
  state_t ret_norm, ret_norm_next;
  state_t ret_shr, ret_shr_next;
  state_t ret_gcd, ret_gcd_next;
  state_t ret_unit, ret_unit_next;
  logic   is_mul;

  function automatic rma_pkg::dp_cmd_t ucmd(rma_pkg::dp_op_t op, logic mul,
                                            rma_pkg::src_t a, rma_pkg::src_t b);
    rma_pkg::dp_cmd_t c;
    c.op     = op;
    c.ustart = 1'b1;
    c.umul   = mul;
    c.ua     = a;
    c.ub     = b;
    c.err    = rma_pkg::ERR_OK;
    return c;
  endfunction

  assign busy   = state != S_IDLE;
  assign is_mul = st.op == rma_pkg::REQ_MUL;

  always_comb begin
    state_next    = state;
    ret_norm_next = ret_norm;
    ret_shr_next  = ret_shr;
    ret_gcd_next  = ret_gcd;
    ret_unit_next = ret_unit;
    cmd.op        = rma_pkg::OP_NOP;
    cmd.ustart    = 1'b0;
    cmd.umul      = 1'b0;
    cmd.ua        = rma_pkg::SRC_X;
    cmd.ub        = rma_pkg::SRC_Y;
    cmd.err       = rma_pkg::ERR_OK;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op     = rma_pkg::OP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (st.op > rma_pkg::REQ_CMP) begin
          cmd.op     = rma_pkg::OP_OUT_ZERO;
          state_next = S_IDLE;
        end else begin
          cmd.op        = rma_pkg::OP_NA_SET;
          ret_norm_next = S_A_DONE;
          state_next    = S_NORM;
        end
      end
      S_NORM: begin
        if (st.d_zero) begin
          cmd.op     = rma_pkg::OP_OUT_ERR;
          cmd.err    = rma_pkg::ERR_ZERO_DEN;
          state_next = S_IDLE;
        end else begin
          ret_shr_next = S_NQ;
          state_next   = S_SHR;
        end
      end
      S_SHR: begin
        if (st.n_zero) begin
          state_next = ret_shr;
        end else if (st.d_zero) begin
          cmd.op     = rma_pkg::OP_OUT_ERR;
          cmd.err    = rma_pkg::ERR_DIV_ZERO;
          state_next = S_IDLE;
        end else begin
          state_next = S_STRIP;
        end
      end
      S_STRIP: begin
        if (st.both_even) begin
          cmd.op = rma_pkg::OP_STRIP;
        end else begin
          cmd.op       = rma_pkg::OP_GCD_LOAD;
          ret_gcd_next = S_SHR_G1;
          state_next   = S_GCD;
        end
      end
      S_GCD: begin
        cmd.op     = rma_pkg::OP_GSWAP;
        state_next = S_GLOOP;
      end
      S_GLOOP: begin
        if (st.y_zero) begin
          cmd.op     = rma_pkg::OP_GDONE;
          state_next = ret_gcd;
        end else begin
          cmd           = ucmd(rma_pkg::OP_NOP, 1'b0, rma_pkg::SRC_X, rma_pkg::SRC_Y);
          ret_unit_next = S_GSTEP;
          state_next    = S_WAIT;
        end
      end
      S_GSTEP: begin
        cmd.op     = rma_pkg::OP_GSTEP;
        state_next = S_GLOOP;
      end
      S_WAIT: begin
        if (!st.ubusy) begin
          state_next = ret_unit;
        end
      end
      S_SHR_G1: begin
        cmd           = ucmd(rma_pkg::OP_NOP, 1'b0, rma_pkg::SRC_N, rma_pkg::SRC_G);
        ret_unit_next = S_SHR_G2;
        state_next    = S_WAIT;
      end
      S_SHR_G2: begin
        cmd           = ucmd(rma_pkg::OP_N_Q, 1'b0, rma_pkg::SRC_D, rma_pkg::SRC_G);
        ret_unit_next = S_SHR_G3;
        state_next    = S_WAIT;
      end
      S_SHR_G3: begin
        cmd.op     = rma_pkg::OP_D_Q;
        state_next = ret_shr;
      end
      S_NQ: begin
        cmd           = ucmd(rma_pkg::OP_NOP, 1'b0, rma_pkg::SRC_N, rma_pkg::SRC_D);
        ret_unit_next = S_NFIN;
        state_next    = S_WAIT;
      end
      S_NFIN: begin
        cmd.op     = rma_pkg::OP_NFIN;
        state_next = ret_norm;
      end
      S_A_DONE: begin
        if (st.op == rma_pkg::REQ_NORM) begin
          cmd.op     = rma_pkg::OP_OUT_VAL;
          state_next = S_IDLE;
        end else begin
          cmd.op        = rma_pkg::OP_A_STORE_BSET;
          ret_norm_next = S_B_DONE;
          state_next    = S_NORM;
        end
      end
      S_B_DONE: begin
        if (is_mul || (st.op == rma_pkg::REQ_DIV)) begin
          cmd.op     = rma_pkg::OP_B_STORE;
          state_next = S_MD0;
        end else begin
          cmd.op       = rma_pkg::OP_B_STORE_LCM;
          ret_gcd_next = S_L1;
          state_next   = S_GCD;
        end
      end
      S_L1: begin
        cmd           = ucmd(rma_pkg::OP_NOP, 1'b0, rma_pkg::SRC_AD, rma_pkg::SRC_G);
        ret_unit_next = S_L2;
        state_next    = S_WAIT;
      end
      S_L2: begin
        cmd           = ucmd(rma_pkg::OP_NOP, 1'b1, rma_pkg::SRC_Q, rma_pkg::SRC_BD);
        ret_unit_next = S_L3;
        state_next    = S_WAIT;
      end
      S_L3: begin
        cmd           = ucmd(rma_pkg::OP_L_SET, 1'b0, rma_pkg::SRC_R, rma_pkg::SRC_AD);
        ret_unit_next = S_L4;
        state_next    = S_WAIT;
      end
      S_L4: begin
        cmd           = ucmd(rma_pkg::OP_NOP, 1'b1, rma_pkg::SRC_Q, rma_pkg::SRC_AN);
        ret_unit_next = S_L5;
        state_next    = S_WAIT;
      end
      S_L5: begin
        cmd           = ucmd(rma_pkg::OP_N1_SET, 1'b0, rma_pkg::SRC_L, rma_pkg::SRC_BD);
        ret_unit_next = S_L6;
        state_next    = S_WAIT;
      end
      S_L6: begin
        cmd           = ucmd(rma_pkg::OP_NOP, 1'b1, rma_pkg::SRC_Q, rma_pkg::SRC_BN);
        ret_unit_next = S_L7;
        state_next    = S_WAIT;
      end
      S_L7: begin
        cmd.op     = rma_pkg::OP_N2_SET;
        state_next = S_L8;
      end
      S_L8: begin
        if (st.op == rma_pkg::REQ_ADD) begin
          cmd.op        = rma_pkg::OP_ADD_SET;
          ret_norm_next = S_FIN_VAL;
          state_next    = S_NORM;
        end else if (st.op == rma_pkg::REQ_SUB) begin
          if (st.sub_neg) begin
            cmd.op     = rma_pkg::OP_OUT_ERR;
            cmd.err    = rma_pkg::ERR_NEGATIVE;
            state_next = S_IDLE;
          end else begin
            cmd.op        = rma_pkg::OP_SUB_SET;
            ret_norm_next = S_FIN_VAL;
            state_next    = S_NORM;
          end
        end else begin
          cmd.op     = rma_pkg::OP_OUT_CMP;
          state_next = S_IDLE;
        end
      end
      S_MD0: begin
        cmd           = ucmd(rma_pkg::OP_NOP, 1'b1, rma_pkg::SRC_AW, rma_pkg::SRC_AD);
        ret_unit_next = S_MD1;
        state_next    = S_WAIT;
      end
      S_MD1: begin
        cmd           = ucmd(rma_pkg::OP_N1_MD, 1'b1, rma_pkg::SRC_BW, rma_pkg::SRC_BD);
        ret_unit_next = S_MD2;
        state_next    = S_WAIT;
      end
      S_MD2: begin
        cmd.op     = rma_pkg::OP_N2_MD;
        state_next = S_MD3;
      end
      S_MD3: begin
        cmd.op       = is_mul ? rma_pkg::OP_MD3_MUL : rma_pkg::OP_MD3_DIV;
        ret_shr_next = S_MD4;
        state_next   = S_SHR;
      end
      S_MD4: begin
        cmd.op       = is_mul ? rma_pkg::OP_MD4_MUL : rma_pkg::OP_MD4_DIV;
        ret_shr_next = S_MD5;
        state_next   = S_SHR;
      end
      S_MD5: begin
        cmd.op     = is_mul ? rma_pkg::OP_MD5_MUL : rma_pkg::OP_MD5_DIV;
        state_next = S_MD6;
      end
      S_MD6: begin
        cmd = ucmd(rma_pkg::OP_NOP, 1'b1, rma_pkg::SRC_N1,
                   is_mul ? rma_pkg::SRC_N2 : rma_pkg::SRC_BD);
        ret_unit_next = S_MD7;
        state_next    = S_WAIT;
      end
      S_MD7: begin
        cmd = ucmd(rma_pkg::OP_MD7, 1'b1, rma_pkg::SRC_AD,
                   is_mul ? rma_pkg::SRC_BD : rma_pkg::SRC_N2);
        ret_unit_next = S_MD8;
        state_next    = S_WAIT;
      end
      S_MD8: begin
        cmd.op        = rma_pkg::OP_MD8;
        ret_norm_next = S_FIN_VAL;
        state_next    = S_NORM;
      end
      S_FIN_VAL: begin
        cmd.op     = rma_pkg::OP_OUT_VAL;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      ret_norm <= S_IDLE;
      ret_shr  <= S_IDLE;
      ret_gcd  <= S_IDLE;
      ret_unit <= S_IDLE;
    end else begin
      state    <= state_next;
      ret_norm <= ret_norm_next;
      ret_shr  <= ret_shr_next;
      ret_gcd  <= ret_gcd_next;
      ret_unit <= ret_unit_next;
    end
  end

  a_unit_idle_on_wait_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT && state_next != S_WAIT) |-> !st.ubusy)
    else $error("left unit wait while unit busy");

  a_start_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.ustart |-> (state != S_IDLE && !st.ubusy))
    else $error("unit started while busy or idle");

  a_onehot_state: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("controller state not one-hot");

endmodule

// ----- rtl/core/rational_mixed_number_alu.sv -----
// Top level of the rational mixed-number ALU: controller plus datapath.
// Run time is data dependent: every divide, remainder and product runs on one shared unit
//   at one bit a cycle, each Euclid step of a GCD is one use of that unit, and a multiply
//   runs up to five GCDs of up to ~93 steps each.
// Throughput: one request at a time; busy stays high until the result beat is issued.
// Results: done marks each result beat for exactly one cycle; the receiver cannot stall.
// Reset: synchronous rst returns the controller to idle and clears done.
module rational_mixed_number_alu #(
  parameter int VALUE_WIDTH = rma_pkg::VALUE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [2:0]                     req_type,
  input  logic [rma_pkg::PORT_WIDTH-1:0] a_integer,
  input  logic [rma_pkg::PORT_WIDTH-1:0] a_numerator,
  input  logic [rma_pkg::PORT_WIDTH-1:0] a_denominator,
  input  logic [rma_pkg::PORT_WIDTH-1:0] b_integer,
  input  logic [rma_pkg::PORT_WIDTH-1:0] b_numerator,
  input  logic [rma_pkg::PORT_WIDTH-1:0] b_denominator,
  output logic                           done,
  output logic [rma_pkg::PORT_WIDTH-1:0] r_integer,
  output logic [rma_pkg::PORT_WIDTH-1:0] r_numerator,
  output logic [rma_pkg::PORT_WIDTH-1:0] r_denominator,
  output logic                           is_less,
  output logic                           is_equal,
  output logic [1:0]                     error_code
);

  rma_pkg::dp_cmd_t  cmd;
  rma_pkg::dp_stat_t st;

  rma_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  rma_dp #(.W(VALUE_WIDTH)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .req_type      (req_type),
    .a_integer     (a_integer),
    .a_numerator   (a_numerator),
    .a_denominator (a_denominator),
    .b_integer     (b_integer),
    .b_numerator   (b_numerator),
    .b_denominator (b_denominator),
    .done          (done),
    .r_integer     (r_integer),
    .r_numerator   (r_numerator),
    .r_denominator (r_denominator),
    .is_less       (is_less),
    .is_equal      (is_equal),
    .error_code    (error_code)
  );

  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without a result beat");

  a_err_zero_payload: assert property (@(posedge clk) disable iff (rst)
    (done && error_code != rma_pkg::ERR_OK) |->
      (r_integer == '0 && r_numerator == '0 && r_denominator == '0 && !is_less && !is_equal))
    else $error("error beat carries a value");

  a_less_equal_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(is_less && is_equal))
    else $error("compare reports less and equal");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench of the rational mixed-number ALU with its own arithmetic predictor.
module testbench;
  import rma_pkg::*;

  localparam logic [2:0] REQ_SPARE_LO = 3'd6;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;
  localparam logic [63:0] ALL_ONES = '1;

  typedef struct {
    logic [2:0]  op;
    logic [63:0] ai, an, ad, bi, bn, bd;
  } request_t;

  typedef struct {
    logic [63:0] w, n, d;
    logic        lt, eq;
    logic [1:0]  err;
  } outcome_t;

  typedef struct {
    logic [63:0] w, n, d;
  } mixed_t;

  class rational_board;
    outcome_t waiting[$];
    int       errors = 0;

    function logic [63:0] gcd(logic [63:0] x, logic [63:0] y);
      logic [63:0] t;
      if (x < y) begin
        t = x; x = y; y = t;
      end
      while (y != 0) begin
        t = x % y; x = y; y = t;
      end
      return x;
    endfunction

    function logic [63:0] lcm(logic [63:0] x, logic [63:0] y);
      logic [63:0] q;
      q = x / gcd(x, y);
      return q * y;
    endfunction

    function logic [1:0] shrink(inout logic [63:0] n, inout logic [63:0] d);
      logic [63:0] g;
      if (n == 0) return ERR_OK;
      if (d == 0) return ERR_DIV_ZERO;
      while (((n | d) & 64'd1) == 0) begin
        n = n >> 1; d = d >> 1;
      end
      g = gcd(n, d);
      n = n / g; d = d / g;
      return ERR_OK;
    endfunction

    function logic [1:0] normal(logic [63:0] w, logic [63:0] n, logic [63:0] d,
                                output mixed_t r);
      logic [1:0]  e;
      logic [63:0] q;
      r = '{0, 0, 0};
      if (d == 0) return ERR_ZERO_DEN;
      e = shrink(n, d);
      q = n / d;
      r.w = w + q;
      r.n = n - q * d;
      r.d = d;
      return ERR_OK;
    endfunction

    function logic [1:0] sum_diff(mixed_t x, mixed_t y, bit add, output mixed_t r);
      logic [63:0] den, n1, n2, w;
      r = '{0, 0, 0};
      den = lcm(x.d, y.d);
      n1 = x.n * (den / x.d);
      n2 = y.n * (den / y.d);
      if (add) return normal(x.w + y.w, n1 + n2, den, r);
      if (x.w < y.w) return ERR_NEGATIVE;
      w = x.w - y.w;
      if (n1 < n2) begin
        if (w == 0) return ERR_NEGATIVE;
        w = w - 1;
        n1 = n1 + den;
      end
      return normal(w, n1 - n2, den, r);
    endfunction

    function logic [1:0] prod_quot(mixed_t x, mixed_t y, bit mul, output mixed_t r);
      logic [63:0] n1, d1, n2, d2;
      logic [1:0]  e;
      r = '{0, 0, 0};
      n1 = x.w * x.d + x.n; d1 = x.d;
      n2 = y.w * y.d + y.n; d2 = y.d;
      if (mul) begin
        e = shrink(n1, d2);
        if (e == ERR_OK) e = shrink(n2, d1);
        if (e != ERR_OK) return e;
        return normal(0, n1 * n2, d1 * d2, r);
      end
      e = shrink(n1, n2);
      if (e == ERR_OK) e = shrink(d1, d2);
      if (e != ERR_OK) return e;
      return normal(0, n1 * d2, d1 * n2, r);
    endfunction

    function outcome_t predict(request_t q);
      outcome_t o;
      mixed_t   a, b, r;
      logic [63:0] l, lx, ly;
      bit       has_val;
      o = '{0, 0, 0, 0, 0, ERR_OK};
      r = '{0, 0, 0};
      has_val = 0;
      if (q.op <= REQ_CMP) begin
        o.err = normal(q.ai, q.an, q.ad, a);
        if (o.err == ERR_OK && q.op != REQ_NORM) o.err = normal(q.bi, q.bn, q.bd, b);
        if (o.err == ERR_OK) begin
          has_val = 1;
          case (q.op)
            REQ_NORM: r = a;
            REQ_ADD:  o.err = sum_diff(a, b, 1, r);
            REQ_SUB:  o.err = sum_diff(a, b, 0, r);
            REQ_MUL:  o.err = prod_quot(a, b, 1, r);
            REQ_DIV:  o.err = prod_quot(a, b, 0, r);
            default: begin
              has_val = 0;
              if (a.w == b.w) begin
                l = lcm(a.d, b.d);
                lx = (l / a.d) * a.n;
                ly = (l / b.d) * b.n;
                o.lt = lx < ly;
              end else begin
                o.lt = a.w < b.w;
              end
              o.eq = a.w == b.w && a.n == b.n && a.d == b.d;
            end
          endcase
        end
      end
      if (o.err == ERR_OK && has_val) begin
        o.w = r.w; o.n = r.n; o.d = r.d;
      end
      if (o.err != ERR_OK) begin
        o.lt = 0; o.eq = 0;
      end
      return o;
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
    endtask

    function void note(request_t q);
      waiting.push_back(predict(q));
    endfunction

    task check(outcome_t got);
      outcome_t want;
      if (waiting.size() == 0) begin
        report("unexpected beat", '0, '0);
        return;
      end
      want = waiting.pop_front();
      if (got.w !== want.w) report("r_integer", got.w, want.w);
      if (got.n !== want.n) report("r_numerator", got.n, want.n);
      if (got.d !== want.d) report("r_denominator", got.d, want.d);
      if (got.lt !== want.lt) report("is_less", 64'(got.lt), 64'(want.lt));
      if (got.eq !== want.eq) report("is_equal", 64'(got.eq), 64'(want.eq));
      if (got.err !== want.err) report("error_code", 64'(got.err), 64'(want.err));
    endtask
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy, done, is_less, is_equal;
  logic [2:0]  req_type = '0;
  logic [63:0] a_integer = '0, a_numerator = '0, a_denominator = '0;
  logic [63:0] b_integer = '0, b_numerator = '0, b_denominator = '0;
  logic [63:0] r_integer, r_numerator, r_denominator;
  logic [1:0]  error_code;

  rational_board board = new();

  rational_mixed_number_alu DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
    .a_integer(a_integer), .a_numerator(a_numerator), .a_denominator(a_denominator),
    .b_integer(b_integer), .b_numerator(b_numerator), .b_denominator(b_denominator),
    .done(done), .r_integer(r_integer), .r_numerator(r_numerator),
    .r_denominator(r_denominator), .is_less(is_less), .is_equal(is_equal),
    .error_code(error_code)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done)
      board.check('{r_integer, r_numerator, r_denominator, is_less, is_equal, error_code});
  end

  task send(request_t q);
    start <= 1;
    req_type <= q.op;
    a_integer <= q.ai; a_numerator <= q.an; a_denominator <= q.ad;
    b_integer <= q.bi; b_numerator <= q.bn; b_denominator <= q.bd;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note(q);
    @(negedge clk);
  endtask

  task hold(int cycles);
    start <= 0;
    repeat (cycles) @(negedge clk);
  endtask

  task put(logic [2:0] op, logic [63:0] ai, logic [63:0] an, logic [63:0] ad,
           logic [63:0] bi, logic [63:0] bn, logic [63:0] bd);
    send('{op, ai, an, ad, bi, bn, bd});
  endtask

  function logic [63:0] draw(int bits);
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v >> (64 - bits);
  endfunction

  function int pick_bits();
    int s;
    s = $urandom_range(0, 19);
    if (s < 14) return $urandom_range(2, 8);
    if (s < 17) return 16;
    if (s < 18) return 32;
    return 64;
  endfunction

  function request_t random_request();
    request_t    q;
    logic [63:0] t;
    q.op = ($urandom_range(0, 30) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
    q.ai = draw(pick_bits()); q.an = draw(pick_bits()); q.ad = draw(pick_bits());
    q.bi = draw(pick_bits()); q.bn = draw(pick_bits()); q.bd = draw(pick_bits());
    if (q.ad == 0) q.ad = 1;
    if (q.bd == 0) q.bd = 1;
    if ($urandom_range(0, 24) == 0) q.ad = 0;
    if ($urandom_range(0, 24) == 0) q.bd = 0;
    if ($urandom_range(0, 14) == 0) begin
      q.bi = 0; q.bn = 0;
    end
    if (q.op == REQ_SUB && q.ai < q.bi && $urandom_range(0, 3) != 0) begin
      t = q.ai; q.ai = q.bi; q.bi = t;
    end
    if (q.op == REQ_CMP && $urandom_range(0, 3) == 0) begin
      q.bi = q.ai; q.bn = q.an; q.bd = q.ad;
    end
    return q;
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    put(REQ_NORM, 3, 0, 8, 0, 0, 0);
    put(REQ_NORM, 1, 12, 8, 5, 5, 0);
    put(REQ_NORM, 0, 5, 0, 0, 0, 1);
    put(REQ_ADD, 1, 1, 2, 0, 1, 0);
    put(REQ_ADD, ALL_ONES, ALL_ONES, 1, ALL_ONES, 1, 3);
    put(REQ_SUB, 2, 1, 3, 1, 1, 2);
    put(REQ_SUB, 1, 1, 3, 2, 0, 1);
    put(REQ_SUB, 1, 1, 3, 1, 1, 2);
    put(REQ_SUB, ALL_ONES, ALL_ONES, ALL_ONES, 0, ALL_ONES, ALL_ONES);
    put(REQ_MUL, 2, 1, 3, 4, 3, 8);
    put(REQ_MUL, ALL_ONES, 7, 8, ALL_ONES, 3, 4);
    put(REQ_MUL, 0, 0, 5, 3, 1, 0);
    put(REQ_DIV, 1, 1, 2, 0, 0, 7);
    put(REQ_DIV, 0, 0, 3, 0, 0, 5);
    put(REQ_DIV, 3, 1, 4, 2, 2, 3);
    put(REQ_DIV, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    put(REQ_CMP, 1, 2, 4, 1, 1, 2);
    put(REQ_CMP, 1, 1, 3, 1, 1, 2);
    put(REQ_CMP, 2, 0, 1, 1, 9, 10);
    put(REQ_CMP, 0, 0, 1, 0, 0, 0);
    put(REQ_SPARE_LO, 1, 1, 2, 1, 1, 2);
    put(REQ_SPARE_HI, ALL_ONES, ALL_ONES, 0, ALL_ONES, ALL_ONES, 0);
    for (int i = 0; i < 430; i++) begin
      if (i < 370 && $urandom_range(0, 2) == 0) hold($urandom_range(1, 4));
      send(random_request());
    end
    start <= 0;
    while (board.waiting.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000000;
    $display("status: fail");
    $finish;
  end
endmodule

// ----- rational_mixed_number_alu.f -----
rtl/core/rma_pkg.sv
rtl/core/rma_unit.sv
rtl/core/rma_dp.sv
rtl/core/rma_ctrl.sv
rtl/core/rational_mixed_number_alu.sv
test/testbench.sv
